### hw/rtl/vrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Types and constants shared by the vertex rotate and project pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int QUO_WIDTH   = 18;
	localparam int LATENCY     = 23;
	localparam int ADDR_WIDTH  = 6;
	localparam int DATA_WIDTH  = 64;

	typedef enum logic [2:0] {
		REG_ROW0    = 3'd0,
		REG_ROW1    = 3'd1,
		REG_ROW2    = 3'd2,
		REG_DEPTH   = 3'd3,
		REG_HGAIN   = 3'd4,
		REG_VGAIN   = 3'd5,
		REG_CENTREX = 3'd6,
		REG_CENTREY = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic signed [COORD_WIDTH-1:0] pos_z;
	} vertex_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic               divide_skipped;
	} pixel_t;

	// Sideband that travels beside the quotient pipeline.
	typedef struct packed {
		logic valid;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
		logic skip;
	} div_tag_t;

endpackage

### hw/rtl/vrp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module vrp_divider #(
	parameter int NW = 42,
	parameter int DW = 31,
	parameter int QW = 18
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);
	localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [WW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW+1];

	assign rem_s[0] = WW'(num);
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	// The quotient must fit in QW bits; the caller flags the other case.
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [WW-1:0] sub;
		logic          take;
		assign sub  = WW'(den_s[k]) << (QW - 1 - k);
		assign take = rem_s[k] >= sub;
		always_ff @(posedge clk) begin
			quo_s[k+1] <= quo_s[k] | (QW'(take) << (QW - 1 - k));
		end
		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= take ? rem_s[k] - sub : rem_s[k];
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign quo = quo_s[QW];

endmodule

### hw/rtl/vertex_rotate_project_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_project_top
// Rotates a Q8.8 vertex by a 3x3 matrix, projects it and centres it on screen.
// ----------------------------------------------------------------------------
// A vertex passes the product, sum, gain, operand, divide and output stages.
// Throughput: one vertex per cycle; busy is always low, so start may be held.
// The depth divide is an 18 stage bit-per-stage pipeline, which sets latency.
// The receiver cannot stall; every result beat is shown for one cycle.
// Reset clears the valid pipeline and loads the identity matrix, depth 8.0,
// default gains and a centre of (600, 360).
module vertex_rotate_project_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  vrp_pkg::vertex_t                   vertex,
	output logic                               done,
	output vrp_pkg::pixel_t                    pixel,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [vrp_pkg::ADDR_WIDTH-1:0]     paddr,
	input  logic [vrp_pkg::DATA_WIDTH-1:0]     pwdata,
	output logic [vrp_pkg::DATA_WIDTH-1:0]     prdata,
	output logic                               pready
);
	import vrp_pkg::*;

	// Widths: product, accumulator, view values, scaled numerator, divider.
	localparam int CW  = COORD_WIDTH;
	localparam int PW  = CW + 16;
	localparam int AW  = CW + 18;
	localparam int RW  = CW + 6;
	localparam int MW  = RW + 17;
	localparam int ADW = RW + 8;
	localparam int NW  = MW + 1;
	localparam int DW  = ADW + 1;
	localparam int CMW = DW + QUO_WIDTH;

	// ------------------------------------------------------------------
	// Configuration registers. The user must write them only while the pipe
	// is idle; the block does not enforce it. Every stage reads them directly.
	// ------------------------------------------------------------------
	logic [2:0][47:0]   rot_q;
	logic signed [15:0] depth_q;
	logic [15:0]        hgain_q;
	logic [15:0]        vgain_q;
	logic [11:0]        centre_x_q;
	logic [11:0]        centre_y_q;
	reg_idx_t           widx;
	logic               wr_en;

	assign widx   = reg_idx_t'(paddr[5:3]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0]   <= 48'd16384;
			rot_q[1]   <= 48'd16384 << 16;
			rot_q[2]   <= 48'd16384 << 32;
			depth_q    <= 16'sd2048;
			hgain_q    <= 16'd42667;
			vgain_q    <= 16'd44341;
			centre_x_q <= 12'd600;
			centre_y_q <= 12'd360;
		end else if (wr_en) begin
			case (widx)
				REG_ROW0:    rot_q[0]   <= pwdata[47:0];
				REG_ROW1:    rot_q[1]   <= pwdata[47:0];
				REG_ROW2:    rot_q[2]   <= pwdata[47:0];
				REG_DEPTH:   depth_q    <= pwdata[15:0];
				REG_HGAIN:   hgain_q    <= pwdata[15:0];
				REG_VGAIN:   vgain_q    <= pwdata[15:0];
				REG_CENTREX: centre_x_q <= pwdata[11:0];
				REG_CENTREY: centre_y_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_ROW0:    prdata = DATA_WIDTH'(rot_q[0]);
			REG_ROW1:    prdata = DATA_WIDTH'(rot_q[1]);
			REG_ROW2:    prdata = DATA_WIDTH'(rot_q[2]);
			REG_DEPTH:   prdata = DATA_WIDTH'({depth_q});
			REG_HGAIN:   prdata = DATA_WIDTH'(hgain_q);
			REG_VGAIN:   prdata = DATA_WIDTH'(vgain_q);
			REG_CENTREX: prdata = DATA_WIDTH'(centre_x_q);
			REG_CENTREY: prdata = DATA_WIDTH'(centre_y_q);
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 1: the nine coordinate by coefficient products.
	// ------------------------------------------------------------------
	logic                         accept;
	logic                         valid_s1, valid_s2, valid_s3;
	logic signed [2:0][CW-1:0]    pos;
	logic signed [PW-1:0]         prod_s1 [3][3];

	assign accept = start & ~busy;
	assign pos[0] = vertex.pos_x;
	assign pos[1] = vertex.pos_y;
	assign pos[2] = vertex.pos_z;

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			always_ff @(posedge clk) begin
				prod_s1[r][c] <= PW'($signed(pos[c]) * $signed(rot_q[r][16*c +: 16]));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: row sums, rounding to Q.8, negation and the depth offset.
	// ------------------------------------------------------------------
	logic signed [2:0][CW+3:0] rot_row;
	logic signed [RW-1:0]      vx_s2, vy_s2, w_s2;

	for (genvar r = 0; r < 3; r++) begin : g_sum
		logic signed [AW-1:0] acc;
		assign acc = AW'(prod_s1[r][0]) + AW'(prod_s1[r][1]) + AW'(prod_s1[r][2])
			+ AW'(8192);
		assign rot_row[r] = acc[AW-1:14];
	end

	always_ff @(posedge clk) begin
		vx_s2 <= -RW'($signed(rot_row[0]));
		vy_s2 <= -RW'($signed(rot_row[1]));
		w_s2  <= RW'(depth_q) - RW'($signed(rot_row[2]));
	end

	// ------------------------------------------------------------------
	// Stage 3: gain multiply and the divisor. A zero depth divides by
	// 65536 instead, which is the plain Q.16 to pixel rounding.
	// ------------------------------------------------------------------
	logic signed [MW-1:0] nx_s3, ny_s3;
	logic [ADW-1:0]       ad_s3;
	logic                 wneg_s3, skip_s3;
	logic [RW-1:0]        w_abs;
	logic                 w_zero;

	assign w_zero = (w_s2 == '0);
	assign w_abs  = w_s2[RW-1] ? RW'(-w_s2) : RW'(w_s2);

	always_ff @(posedge clk) begin
		nx_s3   <= MW'(vx_s2 * $signed({1'b0, hgain_q}));
		ny_s3   <= MW'(vy_s2 * $signed({1'b0, vgain_q}));
		ad_s3   <= w_zero ? ADW'(65536) : {w_abs, 8'd0};
		wneg_s3 <= w_s2[RW-1];
		skip_s3 <= w_zero;
	end

	// ------------------------------------------------------------------
	// Stage 4: round-half-away operands 2|n|+d over 2d, and a check that
	// the quotient fits the divider (it saturates on screen otherwise).
	// ------------------------------------------------------------------
	logic [NW-1:0] numx_s4, numy_s4;
	logic [DW-1:0] den_s4;
	div_tag_t      tag_s4;
	logic [MW-1:0] ax, ay;
	logic [NW-1:0] numx, numy;
	logic [DW-1:0] den;
	logic [CMW-1:0] lim;

	assign ax   = nx_s3[MW-1] ? MW'(-nx_s3) : MW'(nx_s3);
	assign ay   = ny_s3[MW-1] ? MW'(-ny_s3) : MW'(ny_s3);
	assign numx = {ax, 1'b0} + NW'(ad_s3);
	assign numy = {ay, 1'b0} + NW'(ad_s3);
	assign den  = {ad_s3, 1'b0};
	assign lim  = {den, {QUO_WIDTH{1'b0}}};

	always_ff @(posedge clk) begin
		numx_s4 <= numx;
		numy_s4 <= numy;
		den_s4  <= den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else begin
			tag_s4.valid <= valid_s3;
			tag_s4.neg_x <= nx_s3[MW-1] ^ wneg_s3;
			tag_s4.neg_y <= ny_s3[MW-1] ^ wneg_s3;
			tag_s4.ovf_x <= CMW'(numx) >= lim;
			tag_s4.ovf_y <= CMW'(numy) >= lim;
			tag_s4.skip  <= skip_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// ------------------------------------------------------------------
	// Divide stages, one quotient bit each, with the sideband alongside.
	// ------------------------------------------------------------------
	logic [QUO_WIDTH-1:0] quo_x, quo_y;
	div_tag_t             tag_d [QUO_WIDTH+1];

	vrp_divider #(.NW(NW), .DW(DW), .QW(QUO_WIDTH)) u_div_x (
		.clk (clk), .num (numx_s4), .den (den_s4), .quo (quo_x)
	);
	vrp_divider #(.NW(NW), .DW(DW), .QW(QUO_WIDTH)) u_div_y (
		.clk (clk), .num (numy_s4), .den (den_s4), .quo (quo_y)
	);

	assign tag_d[0] = tag_s4;
	for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_tag
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_d[k+1] <= '0;
			end else begin
				tag_d[k+1] <= tag_d[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stage: sign, centre offset and 16-bit saturation.
	// ------------------------------------------------------------------
	localparam int SW = QUO_WIDTH + 3;

	div_tag_t             tag_f;
	logic [QUO_WIDTH-1:0] qx, qy;
	logic signed [SW-1:0] sx, sy;

	assign tag_f = tag_d[QUO_WIDTH];
	assign qx = tag_f.ovf_x ? '1 : quo_x;
	assign qy = tag_f.ovf_y ? '1 : quo_y;
	assign sx = (tag_f.neg_x ? -SW'(qx) : SW'(qx)) + SW'(centre_x_q);
	assign sy = (tag_f.neg_y ? -SW'(qy) : SW'(qy)) + SW'(centre_y_q);

	function automatic logic [15:0] sat16(input logic signed [SW-1:0] v);
		logic [15:0] res;
		if (v > SW'(32767)) begin
			res = 16'h7fff;
		end else if (v < -SW'(32768)) begin
			res = 16'h8000;
		end else begin
			res = v[15:0];
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tag_f.valid;
		end
	end

	always_ff @(posedge clk) begin
		pixel.screen_x       <= sat16(sx);
		pixel.screen_y       <= sat16(sy);
		pixel.divide_skipped <= tag_f.skip;
	end

endmodule

### hw/rtl/vrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_checker
// Port-level checks on the vertex pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module vrp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic pready
);
	import vrp_pkg::*;

	// Every accepted vertex produces exactly one beat a fixed time later.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted vertex gave no result beat");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result beat with no matching vertex");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && pready)
		else $error("pipeline refused a vertex or a register access");

endmodule

bind vertex_rotate_project_top vrp_checker u_vrp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.pready (pready)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex rotate and project pipeline. Vertices
// stream through a randomly idling driver; a predictor computes each screen
// position and a monitor compares every done beat with the oldest prediction.
// The run walks through several register settings, each written over APB
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
	import vrp_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	vertex_t               vertex = '0;
	logic                  done;
	pixel_t                pixel;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr = '0;
	logic [DATA_WIDTH-1:0] pwdata = '0;
	logic [DATA_WIDTH-1:0] prdata;
	logic                  pready;

	vertex_rotate_project_top u_dut (.*);

	always #5 clk = ~clk;

	// Shadow copy of the block's registers, used by the predictor.
	logic [47:0] row_q [3];
	logic signed [15:0] depth_q;
	logic [15:0] hgain_q, vgain_q;
	logic [11:0] cx_q, cy_q;

	vertex_t vertex_queue [$];
	pixel_t  pixel_queue [$];
	int      errors = 0;
	bit      drive_idle = 1'b0;   // when set the driver never idles
	bit      paused = 1'b0;       // driver holds off while set

	function automatic longint rot_row(logic [47:0] row, vertex_t v);
		longint acc;
		acc = longint'(v.pos_x) * longint'($signed(row[15:0]))
			+ longint'(v.pos_y) * longint'($signed(row[31:16]))
			+ longint'(v.pos_z) * longint'($signed(row[47:32]));
		return (acc + 64'sd8192) >>> 14;
	endfunction

	// Rounded quotient, ties away from zero.
	function automatic longint div_round(longint num, longint den);
		longint an, ad, q;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		q = (2 * an + ad) / (2 * ad);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic logic [15:0] clamp16(longint v);
		if (v > 32767) return 16'h7fff;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic pixel_t project_vertex(vertex_t v);
		longint vx, vy, w, sx, sy;
		pixel_t p;
		vx = -rot_row(row_q[0], v);
		vy = -rot_row(row_q[1], v);
		w = -rot_row(row_q[2], v) + longint'(depth_q);
		p.divide_skipped = (w == 0);
		if (w == 0) begin
			sx = div_round(vx * hgain_q, 65536);
			sy = div_round(vy * vgain_q, 65536);
		end else begin
			sx = div_round(vx * hgain_q, w * 256);
			sy = div_round(vy * vgain_q, w * 256);
		end
		p.screen_x = clamp16(sx + cx_q);
		p.screen_y = clamp16(sy + cy_q);
		return p;
	endfunction

	// Driver: one beat per accepted start; predicted at the accepting edge.
	always @(negedge clk) begin
		if (!paused && vertex_queue.size() != 0 &&
				(drive_idle || $urandom_range(99) >= 35)) begin
			vertex <= vertex_queue.pop_front();
			start <= 1'b1;
		end else begin
			start <= 1'b0;
			vertex <= vertex_t'(48'({$urandom, $urandom}));
		end
	end

	// Prediction happens at the rising edge that accepts the beat.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			pixel_queue.push_back(project_vertex(vertex));
	end

	// Monitor: every done beat is checked against the oldest prediction.
	always @(posedge clk) begin
		pixel_t exp_p;
		if (arst_n && done) begin
			if (pixel_queue.size() == 0) begin
				$error("done beat with no prediction waiting");
				errors++;
			end else begin
				exp_p = pixel_queue.pop_front();
				if (pixel.screen_x !== exp_p.screen_x) begin
					$error("screen_x expected %0d actual %0d", exp_p.screen_x,
						pixel.screen_x);
					errors++;
				end
				if (pixel.screen_y !== exp_p.screen_y) begin
					$error("screen_y expected %0d actual %0d", exp_p.screen_y,
						pixel.screen_y);
					errors++;
				end
				if (pixel.divide_skipped !== exp_p.divide_skipped) begin
					$error("divide_skipped expected %0b actual %0b",
						exp_p.divide_skipped, pixel.divide_skipped);
					errors++;
				end
			end
		end
	end

	// One APB write, setup then access; pready is always high.
	task automatic reg_write(reg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_WIDTH'(8 * idx); pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_ROW0:    row_q[0] = val[47:0];
			REG_ROW1:    row_q[1] = val[47:0];
			REG_ROW2:    row_q[2] = val[47:0];
			REG_DEPTH:   depth_q = val[15:0];
			REG_HGAIN:   hgain_q = val[15:0];
			REG_VGAIN:   vgain_q = val[15:0];
			REG_CENTREX: cx_q = val[11:0];
			default:     cy_q = val[11:0];
		endcase
	endtask

	// Wait until every queued vertex has gone in and every pixel has come out.
	task automatic drain();
		while (vertex_queue.size() != 0 || pixel_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(3))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom_range(32767) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_setting();
		int k;
		for (k = 0; k < 3; k++)
			reg_write(reg_idx_t'(k), {16'h0, rand_coef(), rand_coef(), rand_coef()});
		reg_write(REG_DEPTH,
			64'($urandom_range(3) == 0 ? $urandom : $urandom_range(4096)));
		reg_write(REG_HGAIN, 64'($urandom));
		reg_write(REG_VGAIN, 64'($urandom));
		reg_write(REG_CENTREX, 64'($urandom));
		reg_write(REG_CENTREY, 64'($urandom));
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(1023) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_random(int n);
		vertex_t v;
		for (int i = 0; i < n; i++) begin
			v.pos_x = rand_coord();
			v.pos_y = rand_coord();
			v.pos_z = rand_coord();
			vertex_queue.push_back(v);
		end
	endtask

	initial begin
		row_q[0] = 48'd16384;
		row_q[1] = 48'd16384 << 16;
		row_q[2] = 48'd16384 << 32;
		depth_q = 16'sd2048;
		hgain_q = 16'd42667;
		vgain_q = 16'd44341;
		cx_q = 12'd600;
		cy_q = 12'd360;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under reset values: extremes, plane z = depth gives
		// a zero view depth, and points behind the camera.
		vertex_queue.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
		vertex_queue.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
		vertex_queue.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
		vertex_queue.push_back('{16'sh7fff, 16'sh8000, 16'sh0800});
		vertex_queue.push_back('{16'sh0100, 16'shff00, 16'sh0800});
		vertex_queue.push_back('{16'sh0100, 16'sh0100, 16'sh07ff});
		vertex_queue.push_back('{16'sh0100, 16'sh0100, 16'sh0801});
		vertex_queue.push_back('{16'sh4000, 16'shc000, 16'sh0a00});
		vertex_queue.push_back('{16'sh0080, 16'sh0080, 16'sh0000});
		vertex_queue.push_back('{16'shff80, 16'shff80, 16'sh0000});
		drain();

		// Extreme settings: all ones, most negative and most positive values, zeros.
		reg_write(REG_ROW0, 64'hffff_ffff_ffff);
		reg_write(REG_ROW1, 64'h8000_8000_8000);
		reg_write(REG_ROW2, 64'h7fff_7fff_7fff);
		reg_write(REG_DEPTH, 64'h8000);
		reg_write(REG_HGAIN, 64'hffff);
		reg_write(REG_VGAIN, 64'h0000);
		reg_write(REG_CENTREX, 64'hfff);
		reg_write(REG_CENTREY, 64'h000);
		vertex_queue.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
		vertex_queue.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
		vertex_queue.push_back('{16'sh0001, 16'sh0000, 16'shffff});
		push_random(6);
		drain();

		// Zero depth with identity matrix: z = 0 skips the divide.
		reg_write(REG_ROW0, 64'h0000_0000_4000);
		reg_write(REG_ROW1, 64'h0000_4000_0000);
		reg_write(REG_ROW2, 64'h4000_0000_0000);
		reg_write(REG_DEPTH, 64'h0000);
		reg_write(REG_VGAIN, 64'hffff);
		vertex_queue.push_back('{16'sh7fff, 16'sh8000, 16'sh0000});
		vertex_queue.push_back('{16'sh1234, 16'shedcb, 16'sh0000});
		vertex_queue.push_back('{16'sh0100, 16'sh0100, 16'sh0100});
		drain();

		// Random settings; one phase runs without any idle cycle.
		for (int ph = 0; ph < 9; ph++) begin
			random_setting();
			drive_idle = (ph == 4);
			push_random(100);
			if (ph == 2) begin
				// Sender holds off mid-phase until the pipeline is empty.
				while (vertex_queue.size() > 50) @(posedge clk);
				paused = 1'b1;
				while (pixel_queue.size() != 0) @(posedge clk);
				paused = 1'b0;
			end
			drain();
		end

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
